// ----- hdl/rs_pkg.sv -----
// shared types, constants and the piece plan table for the rectangle subtract pipeline
package rs_pkg;

    // most pieces one input pair can leave behind
    localparam int PIECE_MAX = 4;
    localparam int CNT_W     = 3;
    localparam int IDX_W     = 2;

    // overlap class of B against A on one axis
    typedef enum logic [2:0] {
        CL_AFTER  = 3'd0,
        CL_TAIL   = 3'd1,
        CL_INNER  = 3'd2,
        CL_WHOLE  = 3'd3,
        CL_HEAD   = 3'd4,
        CL_BEFORE = 3'd5
    } t_class;

    // source of a piece's left edge
    typedef enum logic [1:0] {
        XS_AX,
        XS_BX,
        XS_BR
    } t_xsel;

    // source of a piece's top edge
    typedef enum logic [1:0] {
        YS_AY,
        YS_BY,
        YS_BB
    } t_ysel;

    // source of a piece's width
    typedef enum logic [1:0] {
        WS_AW,
        WS_BXAX,
        WS_ARBR,
        WS_BW
    } t_wsel;

    // source of a piece's height
    typedef enum logic [2:0] {
        HS_AH,
        HS_BYAY,
        HS_ABBB,
        HS_BH,
        HS_BBAY,
        HS_ABBY
    } t_hsel;

    typedef struct packed {
        t_xsel xsel;
        t_ysel ysel;
        t_wsel wsel;
        t_hsel hsel;
    } t_slot;

    // slot 0 is the first piece to leave
    typedef struct packed {
        logic [CNT_W-1:0]          count;
        t_slot [PIECE_MAX-1:0]     slot;
    } t_plan;

    function automatic t_slot make_slot(t_xsel x, t_ysel y, t_wsel w, t_hsel h);
        t_slot s;
        s.xsel = x;
        s.ysel = y;
        s.wsel = w;
        s.hsel = h;
        return s;
    endfunction

    // which pieces a class pair produces, and in which order
    function automatic t_plan piece_plan(t_class cx, t_class cy, logic b_empty);
        t_plan p;
        p.count = CNT_W'(1);
        for (int i = 0; i < PIECE_MAX; i++) begin
            p.slot[i] = make_slot(XS_AX, YS_AY, WS_AW, HS_AH);
        end
        if (!b_empty) begin
            unique case ({cx, cy})
                {CL_TAIL, CL_TAIL}: begin
                    p.count   = CNT_W'(2);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_AW,   HS_BYAY);
                    p.slot[1] = make_slot(XS_AX, YS_BY, WS_BXAX, HS_ABBY);
                end
                {CL_TAIL, CL_HEAD}: begin
                    p.count   = CNT_W'(2);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_BXAX, HS_BBAY);
                    p.slot[1] = make_slot(XS_AX, YS_BB, WS_AW,   HS_ABBB);
                end
                {CL_HEAD, CL_HEAD}: begin
                    p.count   = CNT_W'(2);
                    p.slot[0] = make_slot(XS_BR, YS_AY, WS_ARBR, HS_BBAY);
                    p.slot[1] = make_slot(XS_AX, YS_BB, WS_AW,   HS_ABBB);
                end
                {CL_HEAD, CL_TAIL}: begin
                    p.count   = CNT_W'(2);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_AW,   HS_BYAY);
                    p.slot[1] = make_slot(XS_BR, YS_BY, WS_ARBR, HS_ABBY);
                end
                {CL_TAIL, CL_INNER}: begin
                    p.count   = CNT_W'(3);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_AW,   HS_BYAY);
                    p.slot[1] = make_slot(XS_AX, YS_BY, WS_BXAX, HS_BH);
                    p.slot[2] = make_slot(XS_AX, YS_BB, WS_AW,   HS_ABBB);
                end
                {CL_INNER, CL_HEAD}: begin
                    p.count   = CNT_W'(3);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_BXAX, HS_AH);
                    p.slot[1] = make_slot(XS_BX, YS_BB, WS_BW,   HS_ABBB);
                    p.slot[2] = make_slot(XS_BR, YS_AY, WS_ARBR, HS_AH);
                end
                {CL_HEAD, CL_INNER}: begin
                    p.count   = CNT_W'(3);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_AW,   HS_BYAY);
                    p.slot[1] = make_slot(XS_BR, YS_BY, WS_ARBR, HS_BH);
                    p.slot[2] = make_slot(XS_AX, YS_BB, WS_AW,   HS_ABBB);
                end
                {CL_INNER, CL_TAIL}: begin
                    p.count   = CNT_W'(3);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_BXAX, HS_AH);
                    p.slot[1] = make_slot(XS_BX, YS_AY, WS_BW,   HS_BYAY);
                    p.slot[2] = make_slot(XS_BR, YS_AY, WS_ARBR, HS_AH);
                end
                {CL_TAIL, CL_WHOLE}: begin
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_BXAX, HS_AH);
                end
                {CL_WHOLE, CL_HEAD}: begin
                    p.slot[0] = make_slot(XS_AX, YS_BB, WS_AW,   HS_ABBB);
                end
                {CL_HEAD, CL_WHOLE}: begin
                    p.slot[0] = make_slot(XS_BR, YS_AY, WS_ARBR, HS_AH);
                end
                {CL_WHOLE, CL_TAIL}: begin
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_AW,   HS_BYAY);
                end
                {CL_WHOLE, CL_INNER}: begin
                    p.count   = CNT_W'(2);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_AW,   HS_BYAY);
                    p.slot[1] = make_slot(XS_AX, YS_BB, WS_AW,   HS_ABBB);
                end
                {CL_INNER, CL_WHOLE}: begin
                    p.count   = CNT_W'(2);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_BXAX, HS_AH);
                    p.slot[1] = make_slot(XS_BR, YS_AY, WS_ARBR, HS_AH);
                end
                {CL_WHOLE, CL_WHOLE}: begin
                    p.count   = CNT_W'(0);
                end
                {CL_INNER, CL_INNER}: begin
                    p.count   = CNT_W'(4);
                    p.slot[0] = make_slot(XS_AX, YS_AY, WS_AW,   HS_BYAY);
                    p.slot[1] = make_slot(XS_AX, YS_BY, WS_BXAX, HS_BH);
                    p.slot[2] = make_slot(XS_BR, YS_BY, WS_ARBR, HS_BH);
                    p.slot[3] = make_slot(XS_AX, YS_BB, WS_AW,   HS_ABBB);
                end
                default: begin
                end
            endcase
        end
        return p;
    endfunction

endpackage

// ----- hdl/rs_edge.sv -----
// stage one: exact last pixels for classification and wrapped far edges
module rs_edge #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [COORD_WIDTH-1:0]        i_ax,
    input  logic [COORD_WIDTH-1:0]        i_ay,
    input  logic [COORD_WIDTH-1:0]        i_aw,
    input  logic [COORD_WIDTH-1:0]        i_ah,
    input  logic [COORD_WIDTH-1:0]        i_bx,
    input  logic [COORD_WIDTH-1:0]        i_by,
    input  logic [COORD_WIDTH-1:0]        i_bw,
    input  logic [COORD_WIDTH-1:0]        i_bh,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [COORD_WIDTH-1:0]        o_ax,
    output logic [COORD_WIDTH-1:0]        o_ay,
    output logic [COORD_WIDTH-1:0]        o_aw,
    output logic [COORD_WIDTH-1:0]        o_ah,
    output logic [COORD_WIDTH-1:0]        o_bx,
    output logic [COORD_WIDTH-1:0]        o_by,
    output logic [COORD_WIDTH-1:0]        o_bw,
    output logic [COORD_WIDTH-1:0]        o_bh,
    output logic [COORD_WIDTH-1:0]        o_ar,
    output logic [COORD_WIDTH-1:0]        o_ab,
    output logic [COORD_WIDTH-1:0]        o_br,
    output logic [COORD_WIDTH-1:0]        o_bb,
    output logic signed [COORD_WIDTH+1:0] o_alast_x,
    output logic signed [COORD_WIDTH+1:0] o_blast_x,
    output logic signed [COORD_WIDTH+1:0] o_alast_y,
    output logic signed [COORD_WIDTH+1:0] o_blast_y
);

    localparam logic signed [COORD_WIDTH+1:0] ONE_E = 1;

    // inclusive last pixel, exact in two extra bits
    function automatic logic signed [COORD_WIDTH+1:0] last_of(
        input logic [COORD_WIDTH-1:0] org,
        input logic [COORD_WIDTH-1:0] len
    );
        logic signed [COORD_WIDTH+1:0] org_e;
        logic signed [COORD_WIDTH+1:0] len_e;
        org_e = {{2{org[COORD_WIDTH-1]}}, org};
        len_e = {2'b00, len};
        return org_e + len_e - ONE_E;
    endfunction

    logic                          r_valid;
    logic [COORD_WIDTH-1:0]        r_ax, r_ay, r_aw, r_ah, r_bx, r_by, r_bw, r_bh;
    logic [COORD_WIDTH-1:0]        r_ar, r_ab, r_br, r_bb;
    logic signed [COORD_WIDTH+1:0] r_alast_x, r_blast_x, r_alast_y, r_blast_y;
    logic [COORD_WIDTH-1:0]        n_ar, n_ab, n_br, n_bb;
    logic signed [COORD_WIDTH+1:0] n_alast_x, n_blast_x, n_alast_y, n_blast_y;

    assign o_stall = r_valid & i_stall;

    // edge arithmetic
    always_comb begin
        n_ar      = i_ax + i_aw;
        n_ab      = i_ay + i_ah;
        n_br      = i_bx + i_bw;
        n_bb      = i_by + i_bh;
        n_alast_x = last_of(i_ax, i_aw);
        n_blast_x = last_of(i_bx, i_bw);
        n_alast_y = last_of(i_ay, i_ah);
        n_blast_y = last_of(i_by, i_bh);
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_ax      <= i_ax;
            r_ay      <= i_ay;
            r_aw      <= i_aw;
            r_ah      <= i_ah;
            r_bx      <= i_bx;
            r_by      <= i_by;
            r_bw      <= i_bw;
            r_bh      <= i_bh;
            r_ar      <= n_ar;
            r_ab      <= n_ab;
            r_br      <= n_br;
            r_bb      <= n_bb;
            r_alast_x <= n_alast_x;
            r_blast_x <= n_blast_x;
            r_alast_y <= n_alast_y;
            r_blast_y <= n_blast_y;
        end
    end

    assign o_valid   = r_valid;
    assign o_ax      = r_ax;
    assign o_ay      = r_ay;
    assign o_aw      = r_aw;
    assign o_ah      = r_ah;
    assign o_bx      = r_bx;
    assign o_by      = r_by;
    assign o_bw      = r_bw;
    assign o_bh      = r_bh;
    assign o_ar      = r_ar;
    assign o_ab      = r_ab;
    assign o_br      = r_br;
    assign o_bb      = r_bb;
    assign o_alast_x = r_alast_x;
    assign o_blast_x = r_blast_x;
    assign o_alast_y = r_alast_y;
    assign o_blast_y = r_blast_y;

endmodule

// ----- hdl/rs_class.sv -----
// stage two: per-axis overlap classes, piece plan and first differences
module rs_class #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [COORD_WIDTH-1:0]        i_ax,
    input  logic [COORD_WIDTH-1:0]        i_ay,
    input  logic [COORD_WIDTH-1:0]        i_aw,
    input  logic [COORD_WIDTH-1:0]        i_ah,
    input  logic [COORD_WIDTH-1:0]        i_bx,
    input  logic [COORD_WIDTH-1:0]        i_by,
    input  logic [COORD_WIDTH-1:0]        i_bw,
    input  logic [COORD_WIDTH-1:0]        i_bh,
    input  logic [COORD_WIDTH-1:0]        i_ar,
    input  logic [COORD_WIDTH-1:0]        i_ab,
    input  logic [COORD_WIDTH-1:0]        i_br,
    input  logic [COORD_WIDTH-1:0]        i_bb,
    input  logic signed [COORD_WIDTH+1:0] i_alast_x,
    input  logic signed [COORD_WIDTH+1:0] i_blast_x,
    input  logic signed [COORD_WIDTH+1:0] i_alast_y,
    input  logic signed [COORD_WIDTH+1:0] i_blast_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output rs_pkg::t_plan                 o_plan,
    output logic [COORD_WIDTH-1:0]        o_ax,
    output logic [COORD_WIDTH-1:0]        o_ay,
    output logic [COORD_WIDTH-1:0]        o_aw,
    output logic [COORD_WIDTH-1:0]        o_ah,
    output logic [COORD_WIDTH-1:0]        o_bx,
    output logic [COORD_WIDTH-1:0]        o_by,
    output logic [COORD_WIDTH-1:0]        o_bw,
    output logic [COORD_WIDTH-1:0]        o_bh,
    output logic [COORD_WIDTH-1:0]        o_ar,
    output logic [COORD_WIDTH-1:0]        o_ab,
    output logic [COORD_WIDTH-1:0]        o_br,
    output logic [COORD_WIDTH-1:0]        o_bb,
    output logic [COORD_WIDTH-1:0]        o_bxax,
    output logic [COORD_WIDTH-1:0]        o_byay,
    output logic [COORD_WIDTH-1:0]        o_bbay,
    output logic [COORD_WIDTH-1:0]        o_abby
);

    // where B sits against A on one axis
    function automatic rs_pkg::t_class axis_class(
        input logic signed [COORD_WIDTH+1:0] a0,
        input logic signed [COORD_WIDTH+1:0] alast,
        input logic signed [COORD_WIDTH+1:0] b0,
        input logic signed [COORD_WIDTH+1:0] blast
    );
        rs_pkg::t_class c;
        if (b0 <= a0) begin
            if (blast < a0) begin
                c = rs_pkg::CL_BEFORE;
            end else if (blast < alast) begin
                c = rs_pkg::CL_HEAD;
            end else begin
                c = rs_pkg::CL_WHOLE;
            end
        end else if (b0 <= alast) begin
            if (blast < alast) begin
                c = rs_pkg::CL_INNER;
            end else begin
                c = rs_pkg::CL_TAIL;
            end
        end else begin
            c = rs_pkg::CL_AFTER;
        end
        return c;
    endfunction

    logic                          r_valid;
    rs_pkg::t_plan                 r_plan, n_plan;
    logic [COORD_WIDTH-1:0]        r_ax, r_ay, r_aw, r_ah, r_bx, r_by, r_bw, r_bh;
    logic [COORD_WIDTH-1:0]        r_ar, r_ab, r_br, r_bb;
    logic [COORD_WIDTH-1:0]        r_bxax, r_byay, r_bbay, r_abby;
    logic [COORD_WIDTH-1:0]        n_bxax, n_byay, n_bbay, n_abby;
    logic signed [COORD_WIDTH+1:0] ax_e, ay_e, bx_e, by_e;
    rs_pkg::t_class                cls_x, cls_y;
    logic                          b_empty;

    assign o_stall = r_valid & i_stall;

    // classify both axes and look up the plan
    always_comb begin
        ax_e    = {{2{i_ax[COORD_WIDTH-1]}}, i_ax};
        ay_e    = {{2{i_ay[COORD_WIDTH-1]}}, i_ay};
        bx_e    = {{2{i_bx[COORD_WIDTH-1]}}, i_bx};
        by_e    = {{2{i_by[COORD_WIDTH-1]}}, i_by};
        cls_x   = axis_class(ax_e, i_alast_x, bx_e, i_blast_x);
        cls_y   = axis_class(ay_e, i_alast_y, by_e, i_blast_y);
        b_empty = (i_bw == '0) | (i_bh == '0);
        n_plan  = rs_pkg::piece_plan(cls_x, cls_y, b_empty);
        n_bxax  = i_bx - i_ax;
        n_byay  = i_by - i_ay;
        n_bbay  = i_bb - i_ay;
        n_abby  = i_ab - i_by;
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_plan <= n_plan;
            r_ax   <= i_ax;
            r_ay   <= i_ay;
            r_aw   <= i_aw;
            r_ah   <= i_ah;
            r_bx   <= i_bx;
            r_by   <= i_by;
            r_bw   <= i_bw;
            r_bh   <= i_bh;
            r_ar   <= i_ar;
            r_ab   <= i_ab;
            r_br   <= i_br;
            r_bb   <= i_bb;
            r_bxax <= n_bxax;
            r_byay <= n_byay;
            r_bbay <= n_bbay;
            r_abby <= n_abby;
        end
    end

    assign o_valid = r_valid;
    assign o_plan  = r_plan;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;
    assign o_aw    = r_aw;
    assign o_ah    = r_ah;
    assign o_bx    = r_bx;
    assign o_by    = r_by;
    assign o_bw    = r_bw;
    assign o_bh    = r_bh;
    assign o_ar    = r_ar;
    assign o_ab    = r_ab;
    assign o_br    = r_br;
    assign o_bb    = r_bb;
    assign o_bxax  = r_bxax;
    assign o_byay  = r_byay;
    assign o_bbay  = r_bbay;
    assign o_abby  = r_abby;

endmodule

// ----- hdl/rs_piece.sv -----
// stage three: builds the up to four pieces of one pair from the plan
module rs_piece #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    output logic                                           o_stall,
    input  rs_pkg::t_plan                                  i_plan,
    input  logic [COORD_WIDTH-1:0]                         i_ax,
    input  logic [COORD_WIDTH-1:0]                         i_ay,
    input  logic [COORD_WIDTH-1:0]                         i_aw,
    input  logic [COORD_WIDTH-1:0]                         i_ah,
    input  logic [COORD_WIDTH-1:0]                         i_bx,
    input  logic [COORD_WIDTH-1:0]                         i_by,
    input  logic [COORD_WIDTH-1:0]                         i_bw,
    input  logic [COORD_WIDTH-1:0]                         i_bh,
    input  logic [COORD_WIDTH-1:0]                         i_ar,
    input  logic [COORD_WIDTH-1:0]                         i_ab,
    input  logic [COORD_WIDTH-1:0]                         i_br,
    input  logic [COORD_WIDTH-1:0]                         i_bb,
    input  logic [COORD_WIDTH-1:0]                         i_bxax,
    input  logic [COORD_WIDTH-1:0]                         i_byay,
    input  logic [COORD_WIDTH-1:0]                         i_bbay,
    input  logic [COORD_WIDTH-1:0]                         i_abby,
    output logic                                           o_valid,
    input  logic                                           i_stall,
    output logic [rs_pkg::CNT_W-1:0]                       o_count,
    output logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0]  o_px,
    output logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0]  o_py,
    output logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0]  o_pw,
    output logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0]  o_ph
);

    logic                                          r_valid;
    logic [rs_pkg::CNT_W-1:0]                      r_count;
    logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0] r_px, r_py, r_pw, r_ph;
    logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0] n_px, n_py, n_pw, n_ph;
    logic [COORD_WIDTH-1:0]                        arbr, abbb;
    rs_pkg::t_slot                                 slot;

    assign o_stall = r_valid & i_stall;

    // remaining differences, then per-slot field selection
    always_comb begin
        arbr = i_ar - i_br;
        abbb = i_ab - i_bb;
        for (int i = 0; i < rs_pkg::PIECE_MAX; i++) begin
            slot = i_plan.slot[i];
            case (slot.xsel)
                rs_pkg::XS_BX: n_px[i] = i_bx;
                rs_pkg::XS_BR: n_px[i] = i_br;
                default:       n_px[i] = i_ax;
            endcase
            case (slot.ysel)
                rs_pkg::YS_BY: n_py[i] = i_by;
                rs_pkg::YS_BB: n_py[i] = i_bb;
                default:       n_py[i] = i_ay;
            endcase
            case (slot.wsel)
                rs_pkg::WS_BXAX: n_pw[i] = i_bxax;
                rs_pkg::WS_ARBR: n_pw[i] = arbr;
                rs_pkg::WS_BW:   n_pw[i] = i_bw;
                default:         n_pw[i] = i_aw;
            endcase
            case (slot.hsel)
                rs_pkg::HS_BYAY: n_ph[i] = i_byay;
                rs_pkg::HS_ABBB: n_ph[i] = abbb;
                rs_pkg::HS_BH:   n_ph[i] = i_bh;
                rs_pkg::HS_BBAY: n_ph[i] = i_bbay;
                rs_pkg::HS_ABBY: n_ph[i] = i_abby;
                default:         n_ph[i] = i_ah;
            endcase
        end
    end

    // stage valid: a pair that leaves nothing ends here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid & (i_plan.count != '0);
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_count <= i_plan.count;
            r_px    <= n_px;
            r_py    <= n_py;
            r_pw    <= n_pw;
            r_ph    <= n_ph;
        end
    end

    assign o_valid = r_valid;
    assign o_count = r_count;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_pw    = r_pw;
    assign o_ph    = r_ph;

endmodule

// ----- hdl/rs_serial.sv -----
// output serialiser: hands out the pieces of one pair one beat at a time
module rs_serial #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    output logic                                           o_stall,
    input  logic [rs_pkg::CNT_W-1:0]                       i_count,
    input  logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0]  i_px,
    input  logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0]  i_py,
    input  logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0]  i_pw,
    input  logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0]  i_ph,
    output logic                                           o_valid,
    input  logic                                           i_stall,
    output logic [COORD_WIDTH-1:0]                         o_left,
    output logic [COORD_WIDTH-1:0]                         o_top,
    output logic [COORD_WIDTH-1:0]                         o_width,
    output logic [COORD_WIDTH-1:0]                         o_height,
    output logic                                           o_last
);

    logic                                          r_busy;
    logic [rs_pkg::IDX_W-1:0]                      r_idx, n_idx;
    logic [rs_pkg::IDX_W-1:0]                      r_last_idx;
    logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0] r_px, r_py, r_pw, r_ph;
    logic                                          at_last;
    logic                                          done;
    logic                                          load;

    // the held pair frees its slot on the beat of its final piece
    assign at_last = (r_idx == r_last_idx);
    assign done    = r_busy & ~i_stall & at_last;
    assign o_stall = r_busy & ~done;
    assign load    = i_valid & ~o_stall;

    // piece index
    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = '0;
        end else if (r_busy && !i_stall) begin
            n_idx = r_idx + 1'b1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // held pieces
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last_idx <= rs_pkg::IDX_W'(i_count - 1'b1);
            r_px       <= i_px;
            r_py       <= i_py;
            r_pw       <= i_pw;
            r_ph       <= i_ph;
        end
    end

    assign o_valid  = r_busy;
    assign o_left   = r_px[r_idx];
    assign o_top    = r_py[r_idx];
    assign o_width  = r_pw[r_idx];
    assign o_height = r_ph[r_idx];
    assign o_last   = at_last;

endmodule

// ----- hdl/rectangle_subtract.sv -----
// top level of the rectangle subtract block
//
// Takes one pair of rectangles A and B per beat and returns, one beat each,
// the zero to four rectangles that cover A with B cut away, the final one
// flagged by last_piece. The work runs through four registered stages
// (edges, overlap classes and plan, piece assembly, output serialiser).
// A new pair can be taken every cycle while the output keeps pace; the
// single output port moves one piece per cycle unless i_stall holds it, so
// a pair with several pieces holds the port until its last piece goes and
// the pairs behind it wait. A pair that leaves nothing costs no output
// beat. Coordinates wrap to COORD_WIDTH bits.
module rectangle_subtract #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_a_left,
    input  logic signed [COORD_WIDTH-1:0] i_a_top,
    input  logic [COORD_WIDTH-1:0]        i_a_width,
    input  logic [COORD_WIDTH-1:0]        i_a_height,
    input  logic signed [COORD_WIDTH-1:0] i_b_left,
    input  logic signed [COORD_WIDTH-1:0] i_b_top,
    input  logic [COORD_WIDTH-1:0]        i_b_width,
    input  logic [COORD_WIDTH-1:0]        i_b_height,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_piece_left,
    output logic signed [COORD_WIDTH-1:0] o_piece_top,
    output logic [COORD_WIDTH-1:0]        o_piece_width,
    output logic [COORD_WIDTH-1:0]        o_piece_height,
    output logic                          o_last_piece
);

    // stage one to two
    logic                          s1_valid, s1_stall;
    logic [COORD_WIDTH-1:0]        s1_ax, s1_ay, s1_aw, s1_ah, s1_bx, s1_by, s1_bw, s1_bh;
    logic [COORD_WIDTH-1:0]        s1_ar, s1_ab, s1_br, s1_bb;
    logic signed [COORD_WIDTH+1:0] s1_alast_x, s1_blast_x, s1_alast_y, s1_blast_y;

    // stage two to three
    logic                          s2_valid, s2_stall;
    rs_pkg::t_plan                 s2_plan;
    logic [COORD_WIDTH-1:0]        s2_ax, s2_ay, s2_aw, s2_ah, s2_bx, s2_by, s2_bw, s2_bh;
    logic [COORD_WIDTH-1:0]        s2_ar, s2_ab, s2_br, s2_bb;
    logic [COORD_WIDTH-1:0]        s2_bxax, s2_byay, s2_bbay, s2_abby;

    // stage three to serialiser
    logic                                          s3_valid, s3_stall;
    logic [rs_pkg::CNT_W-1:0]                      s3_count;
    logic [rs_pkg::PIECE_MAX-1:0][COORD_WIDTH-1:0] s3_px, s3_py, s3_pw, s3_ph;

    logic [COORD_WIDTH-1:0] out_left, out_top;

    // edges
    rs_edge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_ax      (i_a_left),
        .i_ay      (i_a_top),
        .i_aw      (i_a_width),
        .i_ah      (i_a_height),
        .i_bx      (i_b_left),
        .i_by      (i_b_top),
        .i_bw      (i_b_width),
        .i_bh      (i_b_height),
        .o_valid   (s1_valid),
        .i_stall   (s1_stall),
        .o_ax      (s1_ax),
        .o_ay      (s1_ay),
        .o_aw      (s1_aw),
        .o_ah      (s1_ah),
        .o_bx      (s1_bx),
        .o_by      (s1_by),
        .o_bw      (s1_bw),
        .o_bh      (s1_bh),
        .o_ar      (s1_ar),
        .o_ab      (s1_ab),
        .o_br      (s1_br),
        .o_bb      (s1_bb),
        .o_alast_x (s1_alast_x),
        .o_blast_x (s1_blast_x),
        .o_alast_y (s1_alast_y),
        .o_blast_y (s1_blast_y)
    );

    // classes and plan
    rs_class #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_class (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s1_valid),
        .o_stall   (s1_stall),
        .i_ax      (s1_ax),
        .i_ay      (s1_ay),
        .i_aw      (s1_aw),
        .i_ah      (s1_ah),
        .i_bx      (s1_bx),
        .i_by      (s1_by),
        .i_bw      (s1_bw),
        .i_bh      (s1_bh),
        .i_ar      (s1_ar),
        .i_ab      (s1_ab),
        .i_br      (s1_br),
        .i_bb      (s1_bb),
        .i_alast_x (s1_alast_x),
        .i_blast_x (s1_blast_x),
        .i_alast_y (s1_alast_y),
        .i_blast_y (s1_blast_y),
        .o_valid   (s2_valid),
        .i_stall   (s2_stall),
        .o_plan    (s2_plan),
        .o_ax      (s2_ax),
        .o_ay      (s2_ay),
        .o_aw      (s2_aw),
        .o_ah      (s2_ah),
        .o_bx      (s2_bx),
        .o_by      (s2_by),
        .o_bw      (s2_bw),
        .o_bh      (s2_bh),
        .o_ar      (s2_ar),
        .o_ab      (s2_ab),
        .o_br      (s2_br),
        .o_bb      (s2_bb),
        .o_bxax    (s2_bxax),
        .o_byay    (s2_byay),
        .o_bbay    (s2_bbay),
        .o_abby    (s2_abby)
    );

    // piece assembly
    rs_piece #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_piece (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_stall (s2_stall),
        .i_plan  (s2_plan),
        .i_ax    (s2_ax),
        .i_ay    (s2_ay),
        .i_aw    (s2_aw),
        .i_ah    (s2_ah),
        .i_bx    (s2_bx),
        .i_by    (s2_by),
        .i_bw    (s2_bw),
        .i_bh    (s2_bh),
        .i_ar    (s2_ar),
        .i_ab    (s2_ab),
        .i_br    (s2_br),
        .i_bb    (s2_bb),
        .i_bxax  (s2_bxax),
        .i_byay  (s2_byay),
        .i_bbay  (s2_bbay),
        .i_abby  (s2_abby),
        .o_valid (s3_valid),
        .i_stall (s3_stall),
        .o_count (s3_count),
        .o_px    (s3_px),
        .o_py    (s3_py),
        .o_pw    (s3_pw),
        .o_ph    (s3_ph)
    );

    // one piece per output beat
    rs_serial #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s3_valid),
        .o_stall  (s3_stall),
        .i_count  (s3_count),
        .i_px     (s3_px),
        .i_py     (s3_py),
        .i_pw     (s3_pw),
        .i_ph     (s3_ph),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_left   (out_left),
        .o_top    (out_top),
        .o_width  (o_piece_width),
        .o_height (o_piece_height),
        .o_last   (o_last_piece)
    );

    assign o_piece_left = out_left;
    assign o_piece_top  = out_top;

`ifndef SYNTH
    // a piece that is not the last is always followed by another
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_piece && !i_stall |=> o_valid)
        else $error("pair ended before its last piece");

    // back-pressure at the input only comes from a piece waiting at the output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no piece pending");

    // after the final piece the output goes idle unless a pair is ready
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_piece && !i_stall && !s3_valid |=> !o_valid)
        else $error("output beat with no pair behind it");
`endif

endmodule

// ----- tb/rs_checker.sv -----
// checker for the rectangle subtract block: predicts the pieces of each pair and compares beats
`timescale 1ns / 1ps

module rs_checker #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pair channel
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic signed [CW-1:0] i_a_left,
    input  logic signed [CW-1:0] i_a_top,
    input  logic [CW-1:0]        i_a_width,
    input  logic [CW-1:0]        i_a_height,
    input  logic signed [CW-1:0] i_b_left,
    input  logic signed [CW-1:0] i_b_top,
    input  logic [CW-1:0]        i_b_width,
    input  logic [CW-1:0]        i_b_height,
    // piece channel
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic signed [CW-1:0] i_piece_left,
    input  logic signed [CW-1:0] i_piece_top,
    input  logic [CW-1:0]        i_piece_width,
    input  logic [CW-1:0]        i_piece_height,
    input  logic                 i_last_piece,
    // status for the testbench top
    output int                   o_fail_count,
    output int                   o_waiting,
    output int                   o_pairs,
    output int                   o_pieces,
    output int                   o_empty_pairs,
    output int                   o_four_piece_pairs,
    output int                   o_class_pairs
);

    typedef struct packed {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] top;
        logic [CW-1:0]        width;
        logic [CW-1:0]        height;
        logic                 last;
    } t_piece;

    // pieces predicted but not yet seen, oldest first
    t_piece pending_pieces[$];

    int  fail_count        = 0;
    int  pair_count        = 0;
    int  piece_count       = 0;
    int  empty_pair_count  = 0;
    int  four_piece_count  = 0;
    int  class_pair_count  = 0;
    // one flag per class pair, the last one for an empty B
    bit  seen_class_pair [0:64];

    assign o_fail_count       = fail_count;
    assign o_pairs            = pair_count;
    assign o_pieces           = piece_count;
    assign o_empty_pairs      = empty_pair_count;
    assign o_four_piece_pairs = four_piece_count;
    assign o_class_pairs      = class_pair_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // where B falls against A on one axis, using inclusive last pixels
    function automatic rs_pkg::t_class axis_class(input longint a0, input longint alen,
                                                  input longint b0, input longint blen);
        longint a_last;
        longint b_last;
        a_last = a0 + alen - 1;
        b_last = b0 + blen - 1;
        if (b0 <= a0) begin
            if (b_last < a0) return rs_pkg::CL_BEFORE;
            if (b_last < a_last) return rs_pkg::CL_HEAD;
            return rs_pkg::CL_WHOLE;
        end
        if (b0 <= a_last) begin
            if (b_last < a_last) return rs_pkg::CL_INNER;
            return rs_pkg::CL_TAIL;
        end
        return rs_pkg::CL_AFTER;
    endfunction

    // edges are exact here, the stored piece wraps to the port width
    function automatic void add_piece(input longint x, input longint y,
                                      input longint w, input longint h);
        t_piece p;
        p.left   = x[CW-1:0];
        p.top    = y[CW-1:0];
        p.width  = w[CW-1:0];
        p.height = h[CW-1:0];
        p.last   = 1'b0;
        pending_pieces.push_back(p);
    endfunction

    // queue the pieces of A left once B is cut away
    function automatic void cut_rectangle(
        input logic signed [CW-1:0] a_left, input logic signed [CW-1:0] a_top,
        input logic [CW-1:0] a_width, input logic [CW-1:0] a_height,
        input logic signed [CW-1:0] b_left, input logic signed [CW-1:0] b_top,
        input logic [CW-1:0] b_width, input logic [CW-1:0] b_height
    );
        longint ax, ay, aw, ah, bx, by, bw, bh, ar, ab, br, bb;
        rs_pkg::t_class cx, cy;
        logic   b_empty;
        int     first;
        int     made;
        int     shape;
        t_piece final_piece;

        ax = a_left;  ay = a_top;  aw = a_width;  ah = a_height;
        bx = b_left;  by = b_top;  bw = b_width;  bh = b_height;
        ar = ax + aw; ab = ay + ah;
        br = bx + bw; bb = by + bh;
        b_empty = (bw == 0) || (bh == 0);
        cx = axis_class(ax, aw, bx, bw);
        cy = axis_class(ay, ah, by, bh);
        first = pending_pieces.size();

        if (b_empty) begin
            add_piece(ax, ay, aw, ah);
        end else begin
            case ({cx, cy})
                {rs_pkg::CL_TAIL, rs_pkg::CL_TAIL}: begin
                    add_piece(ax, ay, aw, by - ay);
                    add_piece(ax, by, bx - ax, ab - by);
                end
                {rs_pkg::CL_TAIL, rs_pkg::CL_HEAD}: begin
                    add_piece(ax, ay, bx - ax, bb - ay);
                    add_piece(ax, bb, aw, ab - bb);
                end
                {rs_pkg::CL_HEAD, rs_pkg::CL_HEAD}: begin
                    add_piece(br, ay, ar - br, bb - ay);
                    add_piece(ax, bb, aw, ab - bb);
                end
                {rs_pkg::CL_HEAD, rs_pkg::CL_TAIL}: begin
                    add_piece(ax, ay, aw, by - ay);
                    add_piece(br, by, ar - br, ab - by);
                end
                {rs_pkg::CL_TAIL, rs_pkg::CL_INNER}: begin
                    add_piece(ax, ay, aw, by - ay);
                    add_piece(ax, by, bx - ax, bh);
                    add_piece(ax, bb, aw, ab - bb);
                end
                {rs_pkg::CL_INNER, rs_pkg::CL_HEAD}: begin
                    add_piece(ax, ay, bx - ax, ah);
                    add_piece(bx, bb, bw, ab - bb);
                    add_piece(br, ay, ar - br, ah);
                end
                {rs_pkg::CL_HEAD, rs_pkg::CL_INNER}: begin
                    add_piece(ax, ay, aw, by - ay);
                    add_piece(br, by, ar - br, bh);
                    add_piece(ax, bb, aw, ab - bb);
                end
                {rs_pkg::CL_INNER, rs_pkg::CL_TAIL}: begin
                    add_piece(ax, ay, bx - ax, ah);
                    add_piece(bx, ay, bw, by - ay);
                    add_piece(br, ay, ar - br, ah);
                end
                {rs_pkg::CL_TAIL, rs_pkg::CL_WHOLE}: begin
                    add_piece(ax, ay, bx - ax, ah);
                end
                {rs_pkg::CL_WHOLE, rs_pkg::CL_HEAD}: begin
                    add_piece(ax, bb, aw, ab - bb);
                end
                {rs_pkg::CL_HEAD, rs_pkg::CL_WHOLE}: begin
                    add_piece(br, ay, ar - br, ah);
                end
                {rs_pkg::CL_WHOLE, rs_pkg::CL_TAIL}: begin
                    add_piece(ax, ay, aw, by - ay);
                end
                {rs_pkg::CL_WHOLE, rs_pkg::CL_INNER}: begin
                    add_piece(ax, ay, aw, by - ay);
                    add_piece(ax, bb, aw, ab - bb);
                end
                {rs_pkg::CL_INNER, rs_pkg::CL_WHOLE}: begin
                    add_piece(ax, ay, bx - ax, ah);
                    add_piece(br, ay, ar - br, ah);
                end
                {rs_pkg::CL_WHOLE, rs_pkg::CL_WHOLE}: begin
                    // A lies inside B, nothing survives
                end
                {rs_pkg::CL_INNER, rs_pkg::CL_INNER}: begin
                    add_piece(ax, ay, aw, by - ay);
                    add_piece(ax, by, bx - ax, bh);
                    add_piece(br, by, ar - br, bh);
                    add_piece(ax, bb, aw, ab - bb);
                end
                default: begin
                    // no overlap on some axis, A passes whole
                    add_piece(ax, ay, aw, ah);
                end
            endcase
        end

        // flag the final piece of this pair
        made = pending_pieces.size() - first;
        if (made > 0) begin
            final_piece      = pending_pieces.pop_back();
            final_piece.last = 1'b1;
            pending_pieces.push_back(final_piece);
        end

        // tallies for the summary
        pair_count++;
        if (made == 0) empty_pair_count++;
        if (made == 4) four_piece_count++;
        shape = b_empty ? 64 : int'({cx, cy});
        if (!seen_class_pair[shape]) begin
            seen_class_pair[shape] = 1'b1;
            class_pair_count++;
        end
    endfunction

    // compare one piece beat with the oldest prediction
    task automatic check_piece();
        t_piece want;
        if (pending_pieces.size() == 0) begin
            report_mismatch($sformatf("piece (%0d,%0d) %0dx%0d with no pair waiting",
                                      i_piece_left, i_piece_top, i_piece_width,
                                      i_piece_height));
        end else begin
            want = pending_pieces.pop_front();
            if (i_piece_left !== want.left)
                report_mismatch($sformatf("piece %0d left %0d, expected %0d",
                                          piece_count, i_piece_left, want.left));
            if (i_piece_top !== want.top)
                report_mismatch($sformatf("piece %0d top %0d, expected %0d",
                                          piece_count, i_piece_top, want.top));
            if (i_piece_width !== want.width)
                report_mismatch($sformatf("piece %0d width %0d, expected %0d",
                                          piece_count, i_piece_width, want.width));
            if (i_piece_height !== want.height)
                report_mismatch($sformatf("piece %0d height %0d, expected %0d",
                                          piece_count, i_piece_height, want.height));
            if (i_last_piece !== want.last)
                report_mismatch($sformatf("piece %0d last %b, expected %b",
                                          piece_count, i_last_piece, want.last));
        end
        piece_count++;
    endtask

    // watch both channels on every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                cut_rectangle(i_a_left, i_a_top, i_a_width, i_a_height,
                              i_b_left, i_b_top, i_b_width, i_b_height);
            if (i_out_valid && !i_out_stall)
                check_piece();
        end
        o_waiting <= pending_pieces.size();
    end

endmodule

// ----- tb/tb_rectangle_subtract.sv -----
// testbench top for the rectangle subtract block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_rectangle_subtract;

    localparam int CW             = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 12;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    logic signed [CW-1:0] i_a_left       = '0;
    logic signed [CW-1:0] i_a_top        = '0;
    logic [CW-1:0]        i_a_width      = '0;
    logic [CW-1:0]        i_a_height     = '0;
    logic signed [CW-1:0] i_b_left       = '0;
    logic signed [CW-1:0] i_b_top        = '0;
    logic [CW-1:0]        i_b_width      = '0;
    logic [CW-1:0]        i_b_height     = '0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    logic signed [CW-1:0] o_piece_left;
    logic signed [CW-1:0] o_piece_top;
    logic [CW-1:0]        o_piece_width;
    logic [CW-1:0]        o_piece_height;
    logic                 o_last_piece;

    int fail_count;
    int pieces_waiting;
    int pair_total;
    int piece_total;
    int empty_pairs;
    int four_piece_pairs;
    int class_pairs;

    // idle chances, in percent, for the sender and the receiver
    int send_idle_pct = 37;
    int stall_pct     = 37;
    int quiet_cycles  = 0;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    rectangle_subtract #(
        .COORD_WIDTH (CW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_a_left       (i_a_left),
        .i_a_top        (i_a_top),
        .i_a_width      (i_a_width),
        .i_a_height     (i_a_height),
        .i_b_left       (i_b_left),
        .i_b_top        (i_b_top),
        .i_b_width      (i_b_width),
        .i_b_height     (i_b_height),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_piece_left   (o_piece_left),
        .o_piece_top    (o_piece_top),
        .o_piece_width  (o_piece_width),
        .o_piece_height (o_piece_height),
        .o_last_piece   (o_last_piece)
    );

    rs_checker #(
        .CW (CW)
    ) u_piece_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_a_left           (i_a_left),
        .i_a_top            (i_a_top),
        .i_a_width          (i_a_width),
        .i_a_height         (i_a_height),
        .i_b_left           (i_b_left),
        .i_b_top            (i_b_top),
        .i_b_width          (i_b_width),
        .i_b_height         (i_b_height),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_piece_left       (o_piece_left),
        .i_piece_top        (o_piece_top),
        .i_piece_width      (o_piece_width),
        .i_piece_height     (o_piece_height),
        .i_last_piece       (o_last_piece),
        .o_fail_count       (fail_count),
        .o_waiting          (pieces_waiting),
        .o_pairs            (pair_total),
        .o_pieces           (piece_total),
        .o_empty_pairs      (empty_pairs),
        .o_four_piece_pairs (four_piece_pairs),
        .o_class_pairs      (class_pairs)
    );

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles where neither channel moves a beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", quiet_cycles);
            $display("tb_rectangle_subtract failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one pair after a random gap and hold it until taken
    task automatic send_pair(input int ax, input int ay, input int aw, input int ah,
                             input int bx, input int by, input int bw, input int bh);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_a_left   <= CW'(ax);
        i_a_top    <= CW'(ay);
        i_a_width  <= CW'(aw);
        i_a_height <= CW'(ah);
        i_b_left   <= CW'(bx);
        i_b_top    <= CW'(by);
        i_b_width  <= CW'(bw);
        i_b_height <= CW'(bh);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // stop sending until every predicted piece has come back
    task automatic drain_pieces();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pieces_waiting != 0) @(posedge i_clk);
    endtask

    // B span on one axis for a wanted class, against A at 10 with length 10
    function automatic void span_for(input rs_pkg::t_class c, output int b0,
                                     output int blen);
        case (c)
            rs_pkg::CL_BEFORE: begin b0 = 0;  blen = 5;  end
            rs_pkg::CL_HEAD:   begin b0 = 5;  blen = 10; end
            rs_pkg::CL_WHOLE:  begin b0 = 10; blen = 10; end
            rs_pkg::CL_INNER:  begin b0 = 12; blen = 4;  end
            rs_pkg::CL_TAIL:   begin b0 = 15; blen = 10; end
            default:           begin b0 = 25; blen = 3;  end
        endcase
    endfunction

    // one axis with B placed near A, so that every class comes up often
    task automatic pick_axis(output int a0, output int alen, output int b0, output int blen);
        int reach;
        int offset;
        a0 = int'($urandom_range(0, 65535));
        if ($urandom_range(99) < 10) alen = int'($urandom_range(0, 65535));
        else alen = int'($urandom_range(0, 24));
        reach  = (alen > 24) ? 24 : alen;
        offset = int'($urandom_range(0, 2 * reach + 8)) - reach - 4;
        b0     = a0 + offset;
        if ($urandom_range(99) < 8) blen = int'($urandom_range(0, 65535));
        else blen = int'($urandom_range(1, 2 * reach + 8));
    endtask

    // mostly overlapping pairs, the rest random over the full field range
    task automatic send_random_pair();
        int ax, ay, aw, ah, bx, by, bw, bh;
        if ($urandom_range(99) < 80) begin
            pick_axis(ax, aw, bx, bw);
            pick_axis(ay, ah, by, bh);
        end else begin
            ax = int'($urandom); ay = int'($urandom);
            aw = int'($urandom); ah = int'($urandom);
            bx = int'($urandom); by = int'($urandom);
            bw = int'($urandom); bh = int'($urandom);
        end
        send_pair(ax, ay, aw, ah, bx, by, bw, bh);
    endtask

    initial begin
        rs_pkg::t_class overlap_kinds [4];
        int bx, by, bw, bh;

        overlap_kinds = '{rs_pkg::CL_HEAD, rs_pkg::CL_WHOLE, rs_pkg::CL_INNER,
                          rs_pkg::CL_TAIL};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every overlapping class pair against a 10x10 A
        foreach (overlap_kinds[i]) begin
            foreach (overlap_kinds[j]) begin
                span_for(overlap_kinds[i], bx, bw);
                span_for(overlap_kinds[j], by, bh);
                send_pair(10, 10, 10, 10, bx, by, bw, bh);
            end
        end

        // no overlap on one axis
        span_for(rs_pkg::CL_INNER, by, bh);
        send_pair(10, 10, 10, 10, 0, by, 5, bh);
        span_for(rs_pkg::CL_INNER, bx, bw);
        send_pair(10, 10, 10, 10, bx, 25, bw, 3);

        // empty B passes A whole
        send_pair(10, 10, 10, 10, 12, 12, 0, 4);
        send_pair(10, 10, 10, 10, 12, 12, 4, 0);

        // empty A, last pixel one before its origin
        send_pair(10, 10, 0, 0, 5, 5, 10, 10);
        send_pair(10, 10, 0, 10, 8, 12, 5, 4);

        // field extremes and edges that wrap
        send_pair(-32768, -32768, 65535, 65535, 0, 0, 1, 1);
        send_pair(32767, 32767, 65535, 65535, 32767, 32767, 2, 2);
        send_pair(100, 100, 5, 5, -32768, -32768, 65535, 65535);

        drain_pieces();

        // random pairs with idling on both sides
        repeat (160) send_random_pair();

        // a long stretch with no idling at all
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (120) send_random_pair();
        send_idle_pct = 37;
        stall_pct     = 37;

        drain_pieces();
        repeat (165) send_random_pair();

        // wind down and leave room for any stray beat
        drain_pieces();
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d pairs giving %0d pieces, %0d of 37 class pairs seen",
                 pair_total, piece_total, class_pairs);
        $display("%0d pairs left nothing behind, %0d were cut into four pieces",
                 empty_pairs, four_piece_pairs);
        if (fail_count == 0) begin
            $display("tb_rectangle_subtract passed");
        end else begin
            $display("tb_rectangle_subtract failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rs_pkg.sv
hdl/rs_edge.sv
hdl/rs_class.sv
hdl/rs_piece.sv
hdl/rs_serial.sv
hdl/rectangle_subtract.sv
tb/rs_checker.sv
tb/tb_rectangle_subtract.sv
